// ===== design/tsin_pkg.sv =====
package tsin_pkg;

  // Field widths of the channels.
  localparam int ANGLE_W = 19;
  localparam int SINE_W  = 18;

  // Fixed-point format: angles are widened from Q16 to Q20 inside.
  localparam int WIDEN_SHIFT = 4;
  localparam int PROD_SHIFT  = 20;

  // Widths of the odd powers in Q20. The angle stays within plus or minus
  // four radians, which bounds every power.
  localparam int X_W  = ANGLE_W + WIDEN_SHIFT;
  localparam int X2_W = 26;
  localparam int P3_W = 28;
  localparam int P5_W = 32;
  localparam int P7_W = 36;
  localparam int P9_W = 40;

  // Factorials of the series.
  localparam int DIV3 = 6;
  localparam int DIV5 = 120;
  localparam int DIV7 = 5040;
  localparam int DIV9 = 362880;

  // Running sum of the series in Q20.
  localparam int ACC_W = 26;

  // Exact special case: half pi returns one.
  localparam int HALF_PI_Q16 = 102944;
  localparam int ONE_Q16     = 65536;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [SINE_W-1:0]  sine_t;
  typedef logic signed [X_W-1:0]     xval_t;
  typedef logic signed [X2_W-1:0]    x2_t;
  typedef logic signed [P3_W-1:0]    p3_t;
  typedef logic signed [P5_W-1:0]    p5_t;
  typedef logic signed [P7_W-1:0]    p7_t;
  typedef logic signed [P9_W-1:0]    p9_t;
  typedef logic signed [ACC_W-1:0]   acc_t;

endpackage

// ===== design/tsin_ifs.sv =====
interface tsin_angle_if;
  import tsin_pkg::*;

  logic   valid;
  logic   ready;
  angle_t angle;

  modport source (output valid, output angle, input ready);
  modport sink (input valid, input angle, output ready);
endinterface

interface tsin_sine_if;
  import tsin_pkg::*;

  logic  valid;
  logic  ready;
  sine_t sine;

  modport source (output valid, output sine, input ready);
  modport sink (input valid, input sine, output ready);
endinterface

// ===== design/fixed_point_taylor_sine.sv =====
// Channel  Direction  Payload                        Beat
// theta    in         angle, signed Q2.16, 19 bits   valid & ready at clk rise
// result   out        sine,  signed Q1.16, 18 bits   valid & ready at clk rise
//
// One beat enters every cycle unless a stall holds the first stage full.
// The stages hold the power chain (one multiplier per stage, x^2 up to
// x^9), then the four-stage divide-by-factorial units and the sum.
// Reset clears only the valid bits of the eleven stages.
// A stage holds its beat while the stage after it is full and cannot move;
// empty stages keep filling, so bubbles close up during a stall.
module fixed_point_taylor_sine (
  input logic         clk,
  input logic         rst,
  tsin_angle_if.sink  theta,
  tsin_sine_if.source result
);
  import tsin_pkg::*;

  localparam int NSTAGE = 11;

  // Quotient widths follow the divider's port width.
  localparam int Q3_W = P3_W - $clog2(DIV3) + 1;
  localparam int Q5_W = P5_W - $clog2(DIV5) + 1;
  localparam int Q7_W = P7_W - $clog2(DIV7) + 1;
  localparam int Q9_W = P9_W - $clog2(DIV9) + 1;

  logic [NSTAGE:1] v;
  logic [NSTAGE:1] adv;
  logic [NSTAGE:1] v_in;
  logic [NSTAGE-1:1] half_d;

  xval_t x1;
  xval_t xd [2:6];
  p3_t   x3;
  p5_t   x5;
  p7_t   x7;
  p9_t   x9;

  logic signed [Q3_W-1:0] q3;
  logic signed [Q5_W-1:0] q5;
  logic signed [Q7_W-1:0] q7;
  logic signed [Q9_W-1:0] q9;

  acc_t  acc7;
  acc_t  acc8;
  acc_t  acc9;
  acc_t  acc10;
  sine_t sine;

  // A stage may load when it is empty or when its beat moves on this cycle.
  // The output register is the last stage.
  always_comb begin
    adv[NSTAGE] = ~v[NSTAGE] | result.ready;
    for (int s = NSTAGE - 1; s >= 1; s--) begin
      adv[s] = ~v[s] | adv[s+1];
    end
  end

  assign v_in         = {v[NSTAGE-1:1], theta.valid};
  assign theta.ready  = adv[1];
  assign result.valid = v[NSTAGE];
  assign result.sine  = sine;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int s = 1; s <= NSTAGE; s++) begin
        if (adv[s]) begin
          v[s] <= v_in[s];
        end
      end
    end
  end

  // Stages 1 to 5: x, x^2 and the odd powers up to x^9.
  tsin_powers u_powers (
    .clk   (clk),
    .adv   (adv[5:1]),
    .angle (theta.angle),
    .x1    (x1),
    .x3    (x3),
    .x5    (x5),
    .x7    (x7),
    .x9    (x9)
  );

  // Each power is divided by its factorial as soon as it appears, so the
  // quotients arrive one stage apart: x^3/3! at stage 6 up to x^9/9! at 9.
  tsin_cdiv #(.W(P3_W), .DIVISOR(DIV3)) u_div3 (
    .clk (clk),
    .adv (adv[6:3]),
    .p   (x3),
    .q   (q3)
  );

  tsin_cdiv #(.W(P5_W), .DIVISOR(DIV5)) u_div5 (
    .clk (clk),
    .adv (adv[7:4]),
    .p   (x5),
    .q   (q5)
  );

  tsin_cdiv #(.W(P7_W), .DIVISOR(DIV7)) u_div7 (
    .clk (clk),
    .adv (adv[8:5]),
    .p   (x7),
    .q   (q7)
  );

  tsin_cdiv #(.W(P9_W), .DIVISOR(DIV9)) u_div9 (
    .clk (clk),
    .adv (adv[9:6]),
    .p   (x9),
    .q   (q9)
  );

  // The angle and the half-pi flag ride along with their beat. Zero needs
  // no flag: every term of a zero angle is zero.
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      half_d[1] <= (theta.angle == ANGLE_W'(HALF_PI_Q16));
    end
    for (int s = 2; s <= NSTAGE - 1; s++) begin
      if (adv[s]) begin
        half_d[s] <= half_d[s-1];
      end
    end
    if (adv[2]) begin
      xd[2] <= x1;
    end
    for (int s = 3; s <= 6; s++) begin
      if (adv[s]) begin
        xd[s] <= xd[s-1];
      end
    end
  end

  // The series is summed one term per stage, in the order the quotients
  // arrive; the last stage returns to Q16 and applies the half-pi case.
  always_ff @(posedge clk) begin
    if (adv[7]) begin
      acc7 <= ACC_W'(xd[6]) - ACC_W'(q3);
    end
    if (adv[8]) begin
      acc8 <= acc7 + ACC_W'(q5);
    end
    if (adv[9]) begin
      acc9 <= acc8 - ACC_W'(q7);
    end
    if (adv[10]) begin
      acc10 <= acc9 + ACC_W'(q9);
    end
    if (adv[11]) begin
      sine <= half_d[10] ? SINE_W'(ONE_Q16) : $signed(acc10[WIDEN_SHIFT +: SINE_W]);
    end
  end

  // A half-pi beat leaves the last stage as exactly one.
  a_half_pi: assert property (@(posedge clk) disable iff (rst)
    adv[11] && v[10] && half_d[10] |=> result.sine == SINE_W'(ONE_Q16))
    else $error("half pi beat did not give one");

  // With the downstream side ready, the whole pipeline moves and accepts.
  a_ready_flow: assert property (@(posedge clk) disable iff (rst)
    result.ready |-> theta.ready)
    else $error("input stalled while output side ready");

  // An accepted beat with none delivered adds exactly one full stage.
  a_count_in: assert property (@(posedge clk) disable iff (rst)
    (theta.valid && theta.ready && !(result.valid && result.ready))
    |=> $countones(v) == $past($countones(v)) + 1)
    else $error("beat lost or duplicated on entry");

  // A delivered beat with none accepted removes exactly one full stage.
  a_count_out: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !(theta.valid && theta.ready))
    |=> $countones(v) + 1 == $past($countones(v)))
    else $error("beat lost or duplicated on exit");

endmodule

// ===== design/tsin_powers.sv =====
module tsin_powers (
  input  logic             clk,
  input  logic [4:0]       adv,
  input  tsin_pkg::angle_t angle,
  output tsin_pkg::xval_t  x1,
  output tsin_pkg::p3_t    x3,
  output tsin_pkg::p5_t    x5,
  output tsin_pkg::p7_t    x7,
  output tsin_pkg::p9_t    x9
);
  import tsin_pkg::*;

  logic signed [2*X_W-1:0]     sq;
  logic signed [X_W+X2_W-1:0]  prod3;
  logic signed [P3_W+X2_W-1:0] prod5;
  logic signed [P5_W+X2_W-1:0] prod7;
  logic signed [P7_W+X2_W-1:0] prod9;
  x2_t   x2_s2;
  x2_t   x2_s3;
  x2_t   x2_s4;
  xval_t x_in;
  x2_t   x2c;

  // Each arithmetic shift right by 20 is a part-select of the product; the
  // bounded range of the angle keeps the upper bits pure sign.
  assign x_in = $signed({angle, {WIDEN_SHIFT{1'b0}}});
  assign x2c  = $signed(sq[PROD_SHIFT +: X2_W]);
  assign x3   = $signed(prod3[PROD_SHIFT +: P3_W]);
  assign x5   = $signed(prod5[PROD_SHIFT +: P5_W]);
  assign x7   = $signed(prod7[PROD_SHIFT +: P7_W]);
  assign x9   = $signed(prod9[PROD_SHIFT +: P9_W]);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x1 <= x_in;
      sq <= x_in * x_in;
    end
    if (adv[1]) begin
      x2_s2 <= x2c;
      prod3 <= x1 * x2c;
    end
    if (adv[2]) begin
      x2_s3 <= x2_s2;
      prod5 <= x3 * x2_s2;
    end
    if (adv[3]) begin
      x2_s4 <= x2_s3;
      prod7 <= x5 * x2_s3;
    end
    if (adv[4]) begin
      prod9 <= x7 * x2_s4;
    end
  end

endmodule

// ===== design/tsin_cdiv.sv =====
module tsin_cdiv #(
  parameter int W       = 28,
  parameter int DIVISOR = 6
) (
  input  logic                                clk,
  input  logic [3:0]                          adv,
  input  logic signed [W-1:0]                 p,
  output logic signed [W-$clog2(DIVISOR):0]   q
);
  // Quotient truncated toward zero: the magnitude is multiplied by a
  // reciprocal that never overshoots, then one compare corrects it.
  localparam int K  = W - 1;
  localparam int DW = $clog2(DIVISOR);
  localparam int MW = K - DW + 1;
  localparam int QW = MW;
  localparam int RW = DW + 1;
  localparam longint unsigned RECIP = (64'd1 << K) / DIVISOR;
  localparam logic [MW-1:0] RECIP_C = MW'(RECIP);

  logic signed [W-1:0] p_neg;
  logic [K-1:0]        mag_next;
  logic [K-1:0]        mag1;
  logic                neg1;
  logic [K-1:0]        mag2;
  logic                neg2;
  logic [K+MW-1:0]     prod2;
  logic [QW-1:0]       q0_next;
  logic [K-1:0]        qd;
  logic [K-1:0]        rem_full;
  logic [QW-1:0]       q03;
  logic [RW-1:0]       rem3;
  logic                neg3;
  logic [QW:0]         qc;
  logic signed [QW:0]  q_next;

  assign p_neg    = -p;
  assign mag_next = p[W-1] ? p_neg[K-1:0] : p[K-1:0];
  assign q0_next  = prod2[K +: QW];
  assign qd       = K'(q0_next) * K'(DIVISOR);
  assign rem_full = mag2 - qd;
  assign qc       = {1'b0, q03} + (QW+1)'(rem3 >= RW'(DIVISOR));
  assign q_next   = neg3 ? -$signed(qc) : $signed(qc);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      mag1 <= mag_next;
      neg1 <= p[W-1];
    end
    if (adv[1]) begin
      mag2  <= mag1;
      neg2  <= neg1;
      prod2 <= (K+MW)'(mag1) * (K+MW)'(RECIP_C);
    end
    if (adv[2]) begin
      q03  <= q0_next;
      rem3 <= rem_full[RW-1:0];
      neg3 <= neg2;
    end
    if (adv[3]) begin
      q <= q_next;
    end
  end

endmodule
